[src/dbcss_pkg.sv]
// shared constants, types and segment table for the debounced button counter
package dbcss_pkg;

   localparam int NumButtons = 8;
   localparam int HistW      = 13;
   localparam int CountW     = 10;
   localparam int SumW       = CountW + 1;
   localparam int SegW       = 8;

   localparam logic [HistW-1:0]  HistAccept = 13'h1000;
   localparam logic [SumW-1:0]   CountMax   = 11'd1023;
   localparam logic [SegW-1:0]   SegBlank   = 8'hFF;

   typedef struct packed {
      logic [SegW-1:0]   seg_ones;
      logic [SegW-1:0]   seg_tens;
      logic [SegW-1:0]   seg_colon;
      logic [SegW-1:0]   seg_hundreds;
      logic [SegW-1:0]   seg_thousands;
      logic [CountW-1:0] count_value;
   } seg_result_type;

   // active-low digit codes, bit0 is segment a
   function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
      logic [SegW-1:0] code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hD8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = SegBlank;
      endcase
      return code;
   endfunction

endpackage

[src/dbcss_lane.sv]
// one button lane: shift history and single-shot press detect
module dbcss_lane (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic level,
   output logic press
);

   logic [dbcss_pkg::HistW-1:0] hist_ff;
   logic [dbcss_pkg::HistW-1:0] hist_in;

   // new level shifts in at the bottom, oldest sample drops off the top
   assign hist_in = {hist_ff[dbcss_pkg::HistW-2:0], level};
   assign press   = enable && (hist_in == dbcss_pkg::HistAccept);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (enable) begin
         hist_ff <= hist_in;
      end
   end

endmodule

[src/dbcss_accum.sv]
// merge of lane presses into the running count with reset-to-zero on overflow
module dbcss_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [dbcss_pkg::NumButtons-1:0] press,
   output logic [dbcss_pkg::CountW-1:0]  count
);

   logic [dbcss_pkg::CountW-1:0] count_ff;
   logic [dbcss_pkg::CountW-1:0] count_in;
   logic [dbcss_pkg::SumW-1:0]   sum;

   // press of lane i weighs 2^i, so the press vector is the increment itself
   assign sum      = {1'b0, count_ff} + dbcss_pkg::SumW'(press);
   assign count_in = (sum > dbcss_pkg::CountMax) ? '0 : sum[dbcss_pkg::CountW-1:0];
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (enable) begin
         count_ff <= count_in;
      end
   end

endmodule

[src/dbcss_segenc.sv]
// decimal split, segment encode and output register
module dbcss_segenc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [dbcss_pkg::CountW-1:0] in_count,
   output logic                         in_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dbcss_pkg::seg_result_type    rsp_result
);

   logic                          out_valid_ff;
   logic                          out_valid_in;
   dbcss_pkg::seg_result_type     result_ff;
   dbcss_pkg::seg_result_type     result_in;
   logic                          load;

   logic                          thou;
   logic [dbcss_pkg::CountW-1:0]  rem_hund;
   logic [3:0]                    hund;
   logic [dbcss_pkg::CountW-1:0]  hund_sub;
   logic [6:0]                    rem_tens;
   logic [3:0]                    tens;
   logic [6:0]                    tens_sub;
   logic [3:0]                    ones;

   assign in_ready = !out_valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   // compare-and-subtract per decimal place, compares within a place run in parallel
   always_comb begin
      thou     = (in_count >= 10'd1000);
      rem_hund = thou ? (in_count - 10'd1000) : in_count;
      hund     = '0;
      hund_sub = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_hund >= dbcss_pkg::CountW'(k * 100)) begin
            hund     = 4'(k);
            hund_sub = dbcss_pkg::CountW'(k * 100);
         end
      end
      rem_tens = 7'(rem_hund - hund_sub);
      tens     = '0;
      tens_sub = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_tens >= 7'(k * 10)) begin
            tens     = 4'(k);
            tens_sub = 7'(k * 10);
         end
      end
      ones = 4'(rem_tens - tens_sub);
   end

   always_comb begin
      result_in.seg_ones      = dbcss_pkg::seg_code(ones);
      result_in.seg_tens      = (in_count < 10'd10) ? dbcss_pkg::SegBlank
                                                    : dbcss_pkg::seg_code(tens);
      result_in.seg_colon     = dbcss_pkg::SegBlank;
      result_in.seg_hundreds  = (in_count < 10'd100) ? dbcss_pkg::SegBlank
                                                     : dbcss_pkg::seg_code(hund);
      result_in.seg_thousands = thou ? dbcss_pkg::seg_code({3'b000, thou})
                                     : dbcss_pkg::SegBlank;
      result_in.count_value   = in_count;
   end

   assign out_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

[src/debounced_button_counter_seven_seg_top.sv]
// Debounced eight-button counter with a four-digit seven-segment readout.
//
// Request channel: one transfer per scan tick, carrying the raw active-low
// button levels (1 released, 0 pressed). Every tick yields exactly one
// response carrying the five segment codes and the running count.
//
// Each button lane keeps a 13-sample history; a press counts once when one
// released sample is followed by twelve pressed samples. Lane i adds 2^i,
// and a count above 1023 returns to zero.
//
// A response is registered first by the lane/count update, then by the
// decimal split into the output register.
// Throughput: one tick per cycle while req_ready is high; the lane and count
// registers update in the cycle the request transfers.
//
// Reset clears all histories, the count and both valid flags; no ready is
// withheld after reset. When the receiver stalls, the output register holds
// its response and one more tick can still be taken into the middle stage;
// req_ready drops only when both stages are full.
module debounced_button_counter_seven_seg_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_button_levels,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_seg_ones,
   output logic [7:0] rsp_seg_tens,
   output logic [7:0] rsp_seg_colon,
   output logic [7:0] rsp_seg_hundreds,
   output logic [7:0] rsp_seg_thousands,
   output logic [9:0] rsp_count_value
);

   logic                                 accept;
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   logic                                 s2_ready;
   logic [dbcss_pkg::NumButtons-1:0]     press;
   logic [dbcss_pkg::CountW-1:0]         count;
   dbcss_pkg::seg_result_type            result;

   assign req_ready = !s1_valid_ff || s2_ready;
   assign accept    = req_valid && req_ready;

   for (genvar i = 0; i < dbcss_pkg::NumButtons; i++) begin : g_lane
      dbcss_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .enable (accept),
         .level  (req_button_levels[i]),
         .press  (press[i])
      );
   end

   dbcss_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .press  (press),
      .count  (count)
   );

   // the count register itself holds the middle-stage payload
   assign s1_valid_in = accept ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   dbcss_segenc u_segenc (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_count   (count),
      .in_ready   (s2_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_seg_ones      = result.seg_ones;
   assign rsp_seg_tens      = result.seg_tens;
   assign rsp_seg_colon     = result.seg_colon;
   assign rsp_seg_hundreds  = result.seg_hundreds;
   assign rsp_seg_thousands = result.seg_thousands;
   assign rsp_count_value   = result.count_value;

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted tick not held in middle stage");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(count)))
      else $error("count changed while middle stage stalled");

   a_load_carries_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> (rsp_valid && rsp_count_value == $past(count)))
      else $error("response count differs from stage count");

   a_colon_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seg_colon == dbcss_pkg::SegBlank))
      else $error("colon slot not blank");

   a_lead_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_value < 10'd10) |->
         (rsp_seg_tens == dbcss_pkg::SegBlank && rsp_seg_hundreds == dbcss_pkg::SegBlank))
      else $error("leading zero not blanked");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the debounced button counter with seven-segment readout
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TicksPerPhase  = 420;
   localparam int HoldOffCycles  = 64;
   localparam int WatchdogLimit  = 2000;
   localparam int DrainCycles    = 4;

   // active-low digit codes, digit d at bits [8*d +: 8]
   localparam logic [79:0] DigitSegments = {
      8'h90, 8'h80, 8'hD8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };

   localparam dbcss_pkg::seg_result_type NoReadout   = '0;
   localparam dbcss_pkg::seg_result_type ZeroReadout =
      {8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd0};
   localparam dbcss_pkg::seg_result_type FullReadout =
      {8'hB0, 8'hA4, 8'hFF, 8'hC0, 8'hF9, 10'd1023};

   typedef struct packed {
      logic [7:0]                levels;
      logic [7:0]                repeats;
      logic                      typed;
      dbcss_pkg::seg_result_type readout;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_button_levels = 8'hFF;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_seg_ones;
   logic [7:0] rsp_seg_tens;
   logic [7:0] rsp_seg_colon;
   logic [7:0] rsp_seg_hundreds;
   logic [7:0] rsp_seg_thousands;
   logic [9:0] rsp_count_value;

   // predictor state
   logic [dbcss_pkg::HistW-1:0]  lane_hist [dbcss_pkg::NumButtons];
   logic [dbcss_pkg::CountW-1:0] count_now;

   dbcss_pkg::seg_result_type pending_readouts [$];
   stim_row_type              directed_rows [21];

   int  mismatches = 0;
   int  ticks_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  hold_off_request = 1'b0;

   debounced_button_counter_seven_seg_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_button_levels (req_button_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_seg_ones      (rsp_seg_ones),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_colon     (rsp_seg_colon),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_thousands (rsp_seg_thousands),
      .rsp_count_value   (rsp_count_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shift one scan tick into the lane histories, add accepted presses, build the readout
   function automatic dbcss_pkg::seg_result_type tally_tick(input logic [7:0] levels);
      dbcss_pkg::seg_result_type r;
      int unsigned               total;
      int                        i;
      total = count_now;
      for (i = 0; i < dbcss_pkg::NumButtons; i++) begin
         lane_hist[i] = {lane_hist[i][dbcss_pkg::HistW-2:0], levels[i]};
         if (lane_hist[i] == dbcss_pkg::HistAccept) total += (32'd1 << i);
      end
      // overflow goes back to zero, not modulo
      if (total > dbcss_pkg::CountMax) total = 0;
      count_now = total[dbcss_pkg::CountW-1:0];
      r.seg_ones      = DigitSegments[8*(total % 10) +: 8];
      r.seg_tens      = (total < 10) ? dbcss_pkg::SegBlank
                                     : DigitSegments[8*((total / 10) % 10) +: 8];
      r.seg_colon     = dbcss_pkg::SegBlank;
      r.seg_hundreds  = (total < 100) ? dbcss_pkg::SegBlank
                                      : DigitSegments[8*((total / 100) % 10) +: 8];
      r.seg_thousands = (total < 1000) ? dbcss_pkg::SegBlank
                                       : DigitSegments[8*((total / 1000) % 10) +: 8];
      r.count_value   = total[dbcss_pkg::CountW-1:0];
      return r;
   endfunction

   task automatic send_tick(input logic [7:0] levels, input logic typed,
                            input dbcss_pkg::seg_result_type typed_readout);
      int                        gap;
      dbcss_pkg::seg_result_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = tally_tick(levels);
      pending_readouts.push_back(typed ? typed_readout : predicted);
      ticks_sent++;
   endtask

   // one random press sequence: mostly clean presses, some bounces and noise
   task automatic press_burst();
      logic [7:0] mask;
      logic [7:0] bg;
      int         kind;
      int         hold;
      kind = $urandom_range(9);
      mask = 8'($urandom_range(1, 255));
      bg   = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'hFF;
      if (kind < 7) begin
         send_tick(bg | mask, 1'b0, NoReadout);
         hold = $urandom_range(12, 16);
         repeat (hold) send_tick(bg & ~mask, 1'b0, NoReadout);
      end else if (kind < 9) begin
         // released too early, must not count
         send_tick(bg | mask, 1'b0, NoReadout);
         hold = $urandom_range(1, 11);
         repeat (hold) send_tick(bg & ~mask, 1'b0, NoReadout);
         send_tick(bg | mask, 1'b0, NoReadout);
      end else begin
         hold = $urandom_range(1, 6);
         repeat (hold) send_tick(8'($urandom_range(255)), 1'b0, NoReadout);
      end
   endtask

   task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // response side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      dbcss_pkg::seg_result_type got;
      dbcss_pkg::seg_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_seg_ones, rsp_seg_tens, rsp_seg_colon, rsp_seg_hundreds,
                rsp_seg_thousands, rsp_count_value};
         if (pending_readouts.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected response, count %0d", $time, rsp_count_value);
         end else begin
            want = pending_readouts.pop_front();
            check_field("seg_ones", {2'b00, want.seg_ones}, {2'b00, got.seg_ones});
            check_field("seg_tens", {2'b00, want.seg_tens}, {2'b00, got.seg_tens});
            check_field("seg_colon", {2'b00, want.seg_colon}, {2'b00, got.seg_colon});
            check_field("seg_hundreds", {2'b00, want.seg_hundreds},
                        {2'b00, got.seg_hundreds});
            check_field("seg_thousands", {2'b00, want.seg_thousands},
                        {2'b00, got.seg_thousands});
            check_field("count_value", want.count_value, got.count_value);
         end
      end
      if (hold_off_request) begin
         hold_left        = HoldOffCycles;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      int phase;
      for (i = 0; i < dbcss_pkg::NumButtons; i++) lane_hist[i] = '0;
      count_now = '0;

      directed_rows = '{
         {8'h00, 8'd13, 1'b1, ZeroReadout},   // pressed from reset, no released sample yet
         {8'hFF, 8'd1,  1'b1, ZeroReadout},
         {8'h00, 8'd12, 1'b0, NoReadout},     // all eight accepted on the last tick
         {8'h00, 8'd20, 1'b0, NoReadout},     // held down, no second count
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'h00, 8'd12, 1'b0, NoReadout},
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'h00, 8'd12, 1'b0, NoReadout},
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'h00, 8'd12, 1'b0, NoReadout},
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'hFC, 8'd11, 1'b0, NoReadout},
         {8'hFC, 8'd1,  1'b1, FullReadout},   // reaches 1023
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'hFE, 8'd11, 1'b0, NoReadout},
         {8'hFE, 8'd1,  1'b1, ZeroReadout},   // 1024 falls back to zero
         {8'hFF, 8'd1,  1'b0, NoReadout},
         {8'h7F, 8'd12, 1'b0, NoReadout},
         {8'hAA, 8'd1,  1'b0, NoReadout},
         {8'h55, 8'd1,  1'b0, NoReadout},
         {8'hAA, 8'd1,  1'b0, NoReadout}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].repeats)
            send_tick(directed_rows[r].levels, directed_rows[r].typed, directed_rows[r].readout);
      end

      // long receiver hold-off so both stages fill and the request side backs up
      hold_off_request = 1'b1;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         ticks_sent = 0;
         while (ticks_sent < TicksPerPhase) press_burst();
      end

      req_valid      <= 1'b0;
      recv_stall_pct = 0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
